/* hdl/rfp_pkg.sv */
// package of the response frame parser: codes, register resets and value helper
package rfp_pkg;

  localparam int unsigned MaxPayloadDefault = 16;
  localparam int unsigned HeaderLen         = 3;
  localparam int unsigned FirstData         = 3;
  localparam int unsigned LastData          = 8;

  localparam logic [7:0] AlertByteReset    = 8'd255;
  localparam logic [6:0] AttachedCodeReset = 7'd1;
  localparam logic [6:0] AngleCodeReset    = 7'd2;
  localparam logic [6:0] PositionCodeReset = 7'd3;

  localparam logic [1:0] RegAlert    = 2'd0;
  localparam logic [1:0] RegAttached = 2'd1;
  localparam logic [1:0] RegAngle    = 2'd2;
  localparam logic [1:0] RegPosition = 2'd3;

  localparam logic [2:0] KindConsole  = 3'd0;
  localparam logic [2:0] KindAttached = 3'd1;
  localparam logic [2:0] KindAngle    = 3'd2;
  localparam logic [2:0] KindPosition = 3'd3;
  localparam logic [2:0] KindOther    = 3'd4;

  // signed high byte times 128 plus signed low byte
  function automatic logic signed [15:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] hi_part;
    logic [15:0] lo_part;
    hi_part = {hi[7], hi, 7'b0};
    lo_part = {{8{lo[7]}}, lo};
    return signed'(hi_part + lo_part);
  endfunction

endpackage

/* hdl/response_frame_parser_top.sv */
// response frame parser: byte stream in, console bytes and decoded reports out
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: rx_byte
//  m_axis    out  m_axis_tvalid/tready      tuser: kind; tdata: echo, attached, angle, x, y, z
//  apb       in   psel/penable/pready       alert, attached, angle, position codes
//
// one byte is taken every cycle while s_axis_tready is high; a byte that ends an item
// has its result in the output register in the cycle after it is accepted
// the output register frees in the same cycle it is taken, so a stalled
// result blocks input only while m_axis_tready is low
// reset clears the parser state and the frame bytes and loads the default codes
module response_frame_parser_top
  import rfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [7:0] echo_byte, [8] attached, [24:9] angle_value,
                                     // [40:25] pos_x, [56:41] pos_y, [72:57] pos_z, rest 0
  output logic [2:0]  m_axis_tuser,  // [2:0] kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LeftW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned WidxW = $clog2(MAX_PAYLOAD + HeaderLen + 1);

  localparam logic [1:0] PhAlert = 2'd0;
  localparam logic [1:0] PhCode  = 2'd1;
  localparam logic [1:0] PhLen   = 2'd2;
  localparam logic [1:0] PhData  = 2'd3;

  // configuration registers
  logic [7:0] alert_q;
  logic [6:0] attached_code_q;
  logic [6:0] angle_code_q;
  logic [6:0] position_code_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_q         <= AlertByteReset;
      attached_code_q <= AttachedCodeReset;
      angle_code_q    <= AngleCodeReset;
      position_code_q <= PositionCodeReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegAlert:    alert_q         <= pwdata[7:0];
        RegAttached: attached_code_q <= pwdata[6:0];
        RegAngle:    angle_code_q    <= pwdata[6:0];
        RegPosition: position_code_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAlert:    prdata = {24'd0, alert_q};
      RegAttached: prdata = {25'd0, attached_code_q};
      RegAngle:    prdata = {25'd0, angle_code_q};
      RegPosition: prdata = {25'd0, position_code_q};
      default:     prdata = 32'd0;
    endcase
  end

  // parser state
  logic [1:0]       phase_q, phase_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [WidxW-1:0] widx_q, widx_d;
  logic [7:0]       code_q, code_d;
  logic [7:0]       data_q [FirstData:LastData];
  logic [7:0]       data_d [FirstData:LastData];

  // result register
  logic        out_valid_q, out_valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  echo_q, echo_d;
  logic        attached_q, attached_d;
  logic [15:0] angle_q, angle_d;
  logic [15:0] pos_x_q, pos_x_d;
  logic [15:0] pos_y_q, pos_y_d;
  logic [15:0] pos_z_q, pos_z_d;

  logic       in_acc;
  logic [7:0] rx;
  logic       emit;
  logic       do_decode;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign rx            = s_axis_tdata;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    widx_d    = widx_q;
    code_d    = code_q;
    data_d    = data_q;
    emit      = 1'b0;
    do_decode = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PhAlert: begin
          if (rx == alert_q) begin
            phase_d = PhCode;
          end else begin
            emit = 1'b1;
          end
        end
        PhCode: begin
          code_d  = rx;
          phase_d = (rx != 8'd0 && !rx[7]) ? PhLen : PhAlert;
        end
        PhLen: begin
          if (rx == 8'd0) begin
            phase_d   = PhAlert;
            emit      = 1'b1;
            do_decode = 1'b1;
          end else if (rx <= 8'(MAX_PAYLOAD)) begin
            left_d  = LeftW'(rx);
            widx_d  = WidxW'(HeaderLen);
            phase_d = PhData;
          end else begin
            phase_d = PhAlert;
          end
        end
        PhData: begin
          for (int i = FirstData; i <= LastData; i++) begin
            if (widx_q == WidxW'(i)) data_d[i] = rx;
          end
          widx_d = widx_q + WidxW'(1);
          left_d = left_q - LeftW'(1);
          if (left_q == LeftW'(1)) begin
            phase_d   = PhAlert;
            widx_d    = '0;
            emit      = 1'b1;
            do_decode = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // decode reads the buffer including the byte just taken
  always_comb begin
    kind_d     = KindConsole;
    echo_d     = 8'd0;
    attached_d = 1'b0;
    angle_d    = 16'd0;
    pos_x_d    = 16'd0;
    pos_y_d    = 16'd0;
    pos_z_d    = 16'd0;
    if (!do_decode) begin
      echo_d = rx;
    end else if (code_q == {1'b0, attached_code_q}) begin
      kind_d     = KindAttached;
      attached_d = (data_d[4] != 8'd0);
    end else if (code_q == {1'b0, angle_code_q}) begin
      kind_d  = KindAngle;
      angle_d = pair_value(data_d[4], data_d[5]);
    end else if (code_q == {1'b0, position_code_q}) begin
      kind_d  = KindPosition;
      pos_x_d = pair_value(data_d[3], data_d[4]);
      pos_y_d = pair_value(data_d[5], data_d[6]);
      pos_z_d = pair_value(data_d[7], data_d[8]);
    end else begin
      kind_d = KindOther;
    end
  end

  assign out_valid_d = emit | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhAlert;
      left_q      <= '0;
      widx_q      <= '0;
      code_q      <= 8'd0;
      out_valid_q <= 1'b0;
      for (int i = FirstData; i <= LastData; i++) data_q[i] <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      widx_q      <= widx_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
      data_q      <= data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= kind_d;
      echo_q     <= echo_d;
      attached_q <= attached_d;
      angle_q    <= angle_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      pos_z_q    <= pos_z_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {7'd0, pos_z_q, pos_y_q, pos_x_q, angle_q, attached_q, echo_q};

  // console byte comes out in the next cycle
  a_console_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PhAlert && s_axis_tdata != alert_q
    |=> m_axis_tvalid && m_axis_tuser == KindConsole && m_axis_tdata[7:0] == $past(s_axis_tdata))
    else $error("console byte not echoed");

  // data phase always expects at least one more byte
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> left_q != '0)
    else $error("data phase with no bytes left");

  // write position never below the first data byte in data phase
  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> widx_q >= WidxW'(HeaderLen))
    else $error("write index below header");

  // no new result while the held one is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !emit)
    else $error("result overwritten while stalled");

  // echo field only carries data for console items
  a_echo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KindConsole |-> m_axis_tdata[7:0] == 8'd0)
    else $error("echo byte set on a frame report");

endmodule

/* sim/frame_check_pkg.sv */
// frame report predictor and result checker for the response frame parser testbench
package frame_check_pkg;
  import rfp_pkg::*;

  localparam int unsigned FrameDepth = HeaderLen + MaxPayloadDefault;
  localparam int HalfScale = 128;

  typedef enum logic [1:0] {
    PhaseAlert,
    PhaseCode,
    PhaseLength,
    PhaseData
  } parse_phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  echo;
    logic        attached;
    logic [15:0] angle;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
  } report_t;

  class frame_report_model;
    logic [7:0]   alert_byte;
    logic [6:0]   attached_code;
    logic [6:0]   angle_code;
    logic [6:0]   position_code;
    parse_phase_e phase;
    logic [7:0]   frame_bytes[FrameDepth];
    logic [6:0]   bytes_left;
    int unsigned  write_index;
    report_t      expected_reports[$];
    int unsigned  mismatches;
    int unsigned  kind_count[5];
    int unsigned  frames_dropped;

    function new();
      alert_byte     = AlertByteReset;
      attached_code  = AttachedCodeReset;
      angle_code     = AngleCodeReset;
      position_code  = PositionCodeReset;
      phase          = PhaseAlert;
      bytes_left     = '0;
      write_index    = 0;
      mismatches     = 0;
      frames_dropped = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegAlert:    alert_byte    = value[7:0];
        RegAttached: attached_code = value[6:0];
        RegAngle:    angle_code    = value[6:0];
        RegPosition: position_code = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] pair_at(int unsigned hi);
      int h;
      int l;
      h = $signed(frame_bytes[hi]);
      l = $signed(frame_bytes[hi + 1]);
      return 16'(h * HalfScale + l);
    endfunction

    function report_t decode();
      report_t r;
      r = '0;
      if (frame_bytes[1] == {1'b0, attached_code}) begin
        r.kind     = KindAttached;
        r.attached = (frame_bytes[4] != 8'd0);
      end else if (frame_bytes[1] == {1'b0, angle_code}) begin
        r.kind  = KindAngle;
        r.angle = pair_at(4);
      end else if (frame_bytes[1] == {1'b0, position_code}) begin
        r.kind  = KindPosition;
        r.pos_x = pair_at(3);
        r.pos_y = pair_at(5);
        r.pos_z = pair_at(7);
      end else begin
        r.kind = KindOther;
      end
      return r;
    endfunction

    function void take_byte(logic [7:0] b);
      report_t r;
      case (phase)
        PhaseAlert: begin
          frame_bytes[0] = b;
          if (b == alert_byte) begin
            phase = PhaseCode;
          end else begin
            r = '0;
            r.kind = KindConsole;
            r.echo = b;
            expected_reports.push_back(r);
          end
        end
        PhaseCode: begin
          frame_bytes[1] = b;
          if (!b[7] && b != 8'd0) begin
            phase = PhaseLength;
          end else begin
            phase = PhaseAlert;
            frames_dropped++;
          end
        end
        PhaseLength: begin
          frame_bytes[2] = b;
          if (b == 8'd0) begin
            phase = PhaseAlert;
            expected_reports.push_back(decode());
          end else if (b <= MaxPayloadDefault) begin
            bytes_left  = b[6:0];
            write_index = HeaderLen;
            phase       = PhaseData;
          end else begin
            phase = PhaseAlert;
            frames_dropped++;
          end
        end
        default: begin
          if (write_index < FrameDepth) frame_bytes[write_index] = b;
          write_index = (write_index + 1) & 32'h7F;
          if (bytes_left > 0) bytes_left = bytes_left - 7'd1;
          if (bytes_left == 0) begin
            phase       = PhaseAlert;
            write_index = 0;
            expected_reports.push_back(decode());
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_report(logic [2:0] kind, logic [79:0] data);
      report_t e;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: kind %0d data %0h", kind, data);
        mismatches++;
        return;
      end
      e = expected_reports.pop_front();
      check_field("kind", 16'(e.kind), 16'(kind));
      check_field("echo_byte", 16'(e.echo), 16'(data[7:0]));
      check_field("attached", 16'(e.attached), 16'(data[8]));
      check_field("angle_value", e.angle, data[24:9]);
      check_field("pos_x", e.pos_x, data[40:25]);
      check_field("pos_y", e.pos_y, data[56:41]);
      check_field("pos_z", e.pos_z, data[72:57]);
      check_field("tdata padding", 16'd0, 16'(data[79:73]));
      if (e.kind <= KindOther) kind_count[e.kind]++;
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
// testbench top: drives byte frames and register settings, checks every report
module tb_top;
  import rfp_pkg::*;
  import frame_check_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // [7:0] echo, [8] attached, [24:9] angle, [40:25] x,
                               // [56:41] y, [72:57] z
  logic [2:0]  m_axis_tuser;   // [2:0] kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_report_model model;
  int unsigned       bytes_sent;
  int unsigned       burst_left;
  int unsigned       settings_applied;
  bit                hold_off_req;

  response_frame_parser_top #(
    .MAX_PAYLOAD(MaxPayloadDefault)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    int unsigned run_left;
    int unsigned mode;
    m_axis_tready = 1'b0;
    run_left = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          mode = $urandom_range(0, 3);
        end
        run_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      model.match_report(m_axis_tuser, m_axis_tdata);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [7:0] alert, logic [6:0] att, logic [6:0] ang,
                                logic [6:0] pos);
    reg_write(RegAlert, {24'd0, alert});
    reg_write(RegAttached, {25'd0, att});
    reg_write(RegAngle, {25'd0, ang});
    reg_write(RegPosition, {25'd0, pos});
    settings_applied++;
  endtask

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    model.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(logic [7:0] code, logic [7:0] len);
    send_byte(model.alert_byte);
    send_byte(code);
    send_byte(len);
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // stray console byte, kept off the alert value
        code = 8'($urandom);
        if (code == model.alert_byte) code = ~code;
        send_byte(code);
      end else if (pick < 19) begin
        send_byte(model.alert_byte);
        send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(128, 255)));
      end else if (pick < 23) begin
        send_header(8'($urandom_range(1, 127)), 8'($urandom_range(MaxPayloadDefault + 1, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0: code = {1'b0, model.attached_code};
          1: code = {1'b0, model.angle_code};
          2, 3: code = {1'b0, model.position_code};
          default: code = 8'($urandom_range(1, 127));
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 6) len = 8'($urandom_range(0, 8));
        else if (pick < 9) len = 8'($urandom_range(0, MaxPayloadDefault));
        else len = 8'(MaxPayloadDefault);
        send_header(code, len);
        repeat (len) send_byte(rand_data());
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (model.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [6:0] same_code;
    model = new();
    bytes_sent = 0;
    burst_left = 0;
    settings_applied = 0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // console bytes, then short and dropped frames; short ones read the buffer as reset or earlier frames left it
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_header({1'b0, PositionCodeReset}, 8'd0);
    send_header({1'b0, AttachedCodeReset}, 8'd2);
    send_byte(8'h01);
    send_byte(8'h00);
    send_header({1'b0, AngleCodeReset}, 8'd2);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(model.alert_byte);
    send_byte(8'h00);
    send_byte(model.alert_byte);
    send_byte(8'h80);
    send_header(8'h7F, 8'(MaxPayloadDefault + 1));
    send_header(8'h7F, 8'd0);
    send_header({1'b0, AttachedCodeReset}, 8'd1);
    send_byte(8'h55);
    drain();

    apply_settings(8'h00, 7'd127, 7'd1, 7'd64);
    send_random(270);
    drain();

    // all codes equal; receiver holds off so the input backs up
    same_code = 7'($urandom_range(1, 127));
    apply_settings(8'($urandom), same_code, same_code, same_code);
    hold_off_req = 1'b1;
    send_random(270);
    drain();

    // attached and angle codes off
    apply_settings(8'($urandom), 7'd0, 7'd0, 7'($urandom_range(1, 127)));
    send_random(270);
    drain();

    same_code = 7'($urandom_range(1, 127));
    apply_settings(8'($urandom), 7'($urandom_range(1, 127)), same_code, same_code);
    send_random(270);
    drain();

    apply_settings(AlertByteReset, AttachedCodeReset, AngleCodeReset, PositionCodeReset);
    send_random(250);
    drain();
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes under %0d register settings, %0d frames dropped",
             bytes_sent, settings_applied + 1, model.frames_dropped);
    $display("checked console %0d, attached %0d, angle %0d, position %0d, other %0d",
             model.kind_count[0], model.kind_count[1], model.kind_count[2],
             model.kind_count[3], model.kind_count[4]);
    if (model.mismatches == 0 && model.expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
